[src/gyroma_pkg.sv]
// Shared widths, constants and types for the gyro rate moving-average block.
package gyroma_pkg;

  localparam int RAW_W       = 16;
  localparam int OFS_W       = 25;
  localparam int SCALE_W     = 18;
  localparam int OUT_W       = 26;
  localparam int FILL_OUT_W  = 4;
  localparam int SCALE_SHIFT = 8;
  localparam int CFG_W       = 25;

  // Product of negated raw (RAW_W+1 signed) and scale (SCALE_W+1 signed).
  localparam int PROD_W = RAW_W + SCALE_W + 2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 18'd146806;

  typedef enum logic [0:0] {
    REG_RATE_OFFSET = 1'b0,
    REG_RATE_SCALE  = 1'b1
  } reg_index_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic shift;   // take the neighbor's sample
    logic active;  // this entry is part of the filled window
  } cell_ctrl_t;

endpackage

[src/gyroma_cell.sv]
// One window cell: holds a sample and, while active, adds it into the partial sum passing by.
module gyroma_cell #(
  parameter int SUM_W = 30
) (
  input  logic                                 clk,
  input  gyroma_pkg::cell_ctrl_t               ctrl,
  input  logic signed [gyroma_pkg::OUT_W-1:0]  sample_in,
  output logic signed [gyroma_pkg::OUT_W-1:0]  sample_out,
  input  logic signed [SUM_W-1:0]              psum_in,
  output logic signed [SUM_W-1:0]              psum_out
);

  logic signed [gyroma_pkg::OUT_W-1:0] sample;
  logic signed [SUM_W-1:0]             psum;
  logic signed [SUM_W-1:0]             addend;

  assign addend     = ctrl.active ? SUM_W'(sample) : '0;
  assign sample_out = sample;
  assign psum_out   = psum;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      sample <= sample_in;
    end
    psum <= psum_in + addend;
  end

endmodule

[src/gyroma_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module gyroma_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] divisor;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};
  assign quot  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= !start && running && (cnt == CNT_W'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(NUM_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= num;
      rem     <= '0;
      divisor <= den;
    end else if (running) begin
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

[src/gyro_rate_offset_moving_average.sv]
// Top level: gyro z-rate scale/offset correction and moving-average filter.
//
//   channel | signals                         | direction | beat
//   --------+---------------------------------+-----------+---------------------------
//   in      | in_valid in_ready raw_rate      | input     | one raw gyro z sample
//   out     | out_valid out_ready avg_rate,   | output    | window average + fill count
//           | window_fill                     |           |
//   cfg     | cfg_we cfg_index cfg_data       | input     | register write, no wait
//
// An item goes through the multiply, the correction, the add chain through
// the cells and the divider before the next beat is accepted; the divider
// retires one quotient bit per cycle.
// A finished result sits in the output register; the block goes idle and takes
// the next beat while it waits. Reset (synchronous) empties the window and
// restores the default scale and zero offset. No clearing pass is needed.
module gyro_rate_offset_moving_average #(
  parameter int WINDOW = 10
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [gyroma_pkg::RAW_W-1:0]     raw_rate,
  // output channel
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [gyroma_pkg::OUT_W-1:0]     avg_rate,
  output logic [gyroma_pkg::FILL_OUT_W-1:0]       window_fill,
  // configuration
  input  logic                                    cfg_we,
  input  gyroma_pkg::reg_index_t                  cfg_index,
  input  logic [gyroma_pkg::CFG_W-1:0]            cfg_data
);

  localparam int OUT_W  = gyroma_pkg::OUT_W;
  localparam int SUM_W  = OUT_W + $clog2(WINDOW);   // sum of WINDOW samples
  localparam int FW     = $clog2(WINDOW + 1);       // fill count width
  localparam int CW     = $clog2(WINDOW + 1);       // sum cycle counter width
  localparam int PROD_W = gyroma_pkg::PROD_W;
  localparam int SH_W   = PROD_W - gyroma_pkg::SCALE_SHIFT;
  localparam int DW     = SH_W + 1;                 // corrected before clamp

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_CORR = 6'b000100,
    S_SUM  = 6'b001000,
    S_LOAD = 6'b010000,
    S_DIV  = 6'b100000
  } state_t;

  // Note: results leave through the output register; S_DIV holds until it is free.

  state_t state;

  // configuration registers
  logic signed [gyroma_pkg::OFS_W-1:0]   rate_offset;
  logic        [gyroma_pkg::SCALE_W-1:0] rate_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_offset <= '0;
      rate_scale  <= gyroma_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gyroma_pkg::REG_RATE_OFFSET: rate_offset <= cfg_data[gyroma_pkg::OFS_W-1:0];
        gyroma_pkg::REG_RATE_SCALE:  rate_scale  <= cfg_data[gyroma_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- scale and offset correction ----
  logic signed [gyroma_pkg::RAW_W-1:0]   raw;
  logic signed [gyroma_pkg::RAW_W:0]     neg_raw;
  logic signed [gyroma_pkg::SCALE_W:0]   scale_s;
  logic signed [PROD_W-1:0]              prod;
  logic signed [SH_W-1:0]                shifted;
  logic signed [DW-1:0]                  diff;
  logic signed [OUT_W-1:0]               corrected;

  assign neg_raw = -{raw[gyroma_pkg::RAW_W-1], raw};
  assign scale_s = {1'b0, rate_scale};
  // floor(prod / 256): arithmetic shift is a plain bit drop
  assign shifted = prod[PROD_W-1:gyroma_pkg::SCALE_SHIFT];
  assign diff    = DW'(shifted) - DW'(rate_offset);

  always_comb begin
    if (diff[DW-1:OUT_W-1] != {(DW - OUT_W + 1){diff[DW-1]}}) begin
      corrected = diff[DW-1] ? {1'b1, {(OUT_W - 1){1'b0}}}
                             : {1'b0, {(OUT_W - 1){1'b1}}};
    end else begin
      corrected = diff[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      raw <= raw_rate;
    end
    if (state == S_MUL) begin
      prod <= neg_raw * scale_s;
    end
  end

  // ---- window: row of cells, newest sample in cell 0 ----
  logic [FW-1:0]                 fill_count;
  logic [CW-1:0]                 sum_cnt;
  logic signed [OUT_W-1:0]       cell_sample [WINDOW];
  logic signed [SUM_W-1:0]       cell_psum   [WINDOW];
  gyroma_pkg::cell_ctrl_t        cell_ctrl   [WINDOW];

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic signed [OUT_W-1:0] s_in;
    logic signed [SUM_W-1:0] p_in;

    if (i == 0) begin : g_head
      assign s_in = corrected;
      assign p_in = '0;
    end else begin : g_body
      assign s_in = cell_sample[i-1];
      assign p_in = cell_psum[i-1];
    end

    assign cell_ctrl[i] = '{shift: (state == S_CORR), active: (FW'(i) < fill_count)};

    gyroma_cell #(
      .SUM_W (SUM_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .sample_in  (s_in),
      .sample_out (cell_sample[i]),
      .psum_in    (p_in),
      .psum_out   (cell_psum[i])
    );
  end

  // ---- divide sum by fill count, truncating toward zero ----
  logic signed [SUM_W-1:0] sum_total;
  logic [SUM_W-1:0]        sum_mag;
  logic                    sum_neg;
  logic                    div_start;
  logic                    div_done;
  logic [SUM_W-1:0]        div_quot;
  logic [SUM_W-1:0]        avg_full;

  assign sum_total = cell_psum[WINDOW-1];
  assign sum_mag   = sum_total[SUM_W-1] ? SUM_W'(-sum_total) : SUM_W'(sum_total);
  assign div_start = (state == S_LOAD);
  assign avg_full  = sum_neg ? -div_quot : div_quot;

  gyroma_div #(
    .NUM_W (SUM_W),
    .DEN_W (FW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sum_mag),
    .den   (fill_count),
    .done  (div_done),
    .quot  (div_quot)
  );

  // quotient is held until the next start, so S_DIV may wait on the output
  logic div_ready;
  logic out_free;
  logic res_load;
  logic [FW+gyroma_pkg::FILL_OUT_W-1:0] fill_ext;

  assign out_free = !out_valid || out_ready;
  assign res_load = (state == S_DIV) && (div_done || div_ready) && out_free;
  assign fill_ext = {{gyroma_pkg::FILL_OUT_W{1'b0}}, fill_count};
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      sum_cnt    <= '0;
      div_ready  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_CORR;
        end
        S_CORR: begin
          if (fill_count != FW'(WINDOW)) begin
            fill_count <= fill_count + 1'b1;
          end
          sum_cnt <= '0;
          state   <= S_SUM;
        end
        S_SUM: begin
          sum_cnt <= sum_cnt + 1'b1;
          if (sum_cnt == CW'(WINDOW - 1)) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          div_ready <= 1'b0;
          state     <= S_DIV;
        end
        S_DIV: begin
          if (res_load) begin
            div_ready <= 1'b0;
            state     <= S_IDLE;
          end else if (div_done) begin
            div_ready <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      sum_neg <= sum_total[SUM_W-1];
    end
    if (res_load) begin
      avg_rate    <= avg_full[OUT_W-1:0];
      window_fill <= fill_ext[gyroma_pkg::FILL_OUT_W-1:0];
    end
  end

`ifndef SYNTHESIS
  // divider only finishes while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider done outside divide state");

  // fill count never passes the window depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FW'(WINDOW))
    else $error("fill count beyond window");

  // an accepted beat always starts the multiply next
  a_accept_mul: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_MUL)
    else $error("accepted beat did not start multiply");

  // a result is never shown for an empty window
  a_out_filled: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fill_count != '0)
    else $error("result with empty window");
`endif

endmodule

[tb/sv/gyroma_avg_monitor.sv]
// Monitor for the gyro rate moving average: predicts each average and checks the output beats.
`timescale 1ns / 1ps

module gyroma_avg_monitor #(
  parameter int WINDOW = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [gyroma_pkg::RAW_W-1:0] raw_rate,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [gyroma_pkg::OUT_W-1:0] avg_rate,
  input  logic [gyroma_pkg::FILL_OUT_W-1:0]   window_fill,
  input  logic                                cfg_we,
  input  gyroma_pkg::reg_index_t              cfg_index,
  input  logic [gyroma_pkg::CFG_W-1:0]        cfg_data,
  output int unsigned                         bad_beats,
  output int unsigned                         outstanding
);

  localparam int     RAW_W       = gyroma_pkg::RAW_W;
  localparam int     OFS_W       = gyroma_pkg::OFS_W;
  localparam int     SCALE_W     = gyroma_pkg::SCALE_W;
  localparam int     OUT_W       = gyroma_pkg::OUT_W;
  localparam int     FILL_OUT_W  = gyroma_pkg::FILL_OUT_W;
  localparam int     SCALE_SHIFT = gyroma_pkg::SCALE_SHIFT;
  localparam longint OUT_MAX     = (longint'(1) << (OUT_W - 1)) - 1;
  localparam longint OUT_MIN     = -(longint'(1) << (OUT_W - 1));

  typedef struct packed {
    logic [OUT_W-1:0]      avg;
    logic [FILL_OUT_W-1:0] fill;
  } avg_beat_t;

  logic signed [OFS_W-1:0] offset_q;
  logic [SCALE_W-1:0]      scale_q;
  longint                  history [WINDOW];  // newest sample at 0
  int unsigned             fill_n;
  avg_beat_t               pending_avgs [$];
  int unsigned             beat_no;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    bad_beats++;
  endtask

  // negate, scale to Q16 dps (floor shift), remove offset, clamp to 26 bits
  function automatic longint corrected_rate(input logic signed [RAW_W-1:0] raw);
    longint prod;
    longint v;
    prod = -longint'(raw) * longint'(scale_q);
    v = (prod >>> SCALE_SHIFT) - longint'(offset_q);
    if (v > OUT_MAX) v = OUT_MAX;
    else if (v < OUT_MIN) v = OUT_MIN;
    return v;
  endfunction

  function automatic avg_beat_t push_sample(input logic signed [RAW_W-1:0] raw);
    longint    sum;
    longint    avg_l;
    avg_beat_t b;
    if (fill_n < WINDOW) fill_n++;
    for (int i = WINDOW - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = corrected_rate(raw);
    sum = 0;
    for (int i = 0; i < fill_n; i++) sum += history[i];
    avg_l  = sum / longint'(fill_n);  // truncates toward zero
    b.avg  = avg_l[OUT_W-1:0];
    b.fill = fill_n[FILL_OUT_W-1:0];
    return b;
  endfunction

  always @(posedge clk) begin
    avg_beat_t got;
    avg_beat_t want;
    if (rst) begin
      offset_q  = '0;
      scale_q   = gyroma_pkg::SCALE_RESET;
      fill_n    = 0;
      beat_no   = 0;
      bad_beats = 0;
      pending_avgs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gyroma_pkg::REG_RATE_OFFSET: offset_q = cfg_data[OFS_W-1:0];
          gyroma_pkg::REG_RATE_SCALE:  scale_q  = cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end
      // output first: a result leaving this edge belongs to an older sample
      if (out_valid && out_ready) begin
        got.avg  = avg_rate;
        got.fill = window_fill;
        if (pending_avgs.size() == 0) begin
          report_mismatch($sformatf("beat %0d: result with nothing pending", beat_no));
        end else begin
          want = pending_avgs.pop_front();
          if (got.avg !== want.avg)
            report_mismatch($sformatf("beat %0d: avg_rate %0d, want %0d", beat_no,
                                      $signed(got.avg), $signed(want.avg)));
          if (got.fill !== want.fill)
            report_mismatch($sformatf("beat %0d: window_fill %0d, want %0d", beat_no,
                                      got.fill, want.fill));
        end
        beat_no++;
      end
      if (in_valid && in_ready) pending_avgs.push_back(push_sample(raw_rate));
    end
    outstanding <= pending_avgs.size();
  end

endmodule

[tb/sv/gyro_rate_offset_moving_average_tb.sv]
// Testbench top for the gyro rate moving average: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module gyro_rate_offset_moving_average_tb;

  localparam int RAW_W        = gyroma_pkg::RAW_W;
  localparam int OUT_W        = gyroma_pkg::OUT_W;
  localparam int FILL_OUT_W   = gyroma_pkg::FILL_OUT_W;
  localparam int CFG_W        = gyroma_pkg::CFG_W;
  localparam int WINDOW       = 10;
  localparam int N_PHASES     = 10;
  localparam int PHASE_ITEMS  = 168;
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int STALL_LIMIT  = 4000;  // cycles with no beat on either channel
  localparam int DRAIN_CYCLES = 64;

  // warm-up samples at the reset scale: zero, both extremes, +-1, alternating
  // bit patterns, then enough beats for the fill count to reach WINDOW and hold
  localparam logic [RAW_W-1:0] WARMUP [12] = '{
    16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h5555,
    16'hAAAA, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000
  };

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [RAW_W-1:0] raw_rate;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [OUT_W-1:0] avg_rate;
  logic [FILL_OUT_W-1:0]   window_fill;
  logic                    cfg_we;
  gyroma_pkg::reg_index_t  cfg_index;
  logic [CFG_W-1:0]        cfg_data;

  int unsigned bad_beats;
  int unsigned outstanding;
  int unsigned quiet_cycles;
  int          in_idle_pct;
  int          out_idle_pct;
  logic        long_hold;

  gyro_rate_offset_moving_average #(
    .WINDOW(WINDOW)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .raw_rate   (raw_rate),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .avg_rate   (avg_rate),
    .window_fill(window_fill),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // prediction and scoring live in the monitor; it hands back the error count
  // and how many averages are still owed
  gyroma_avg_monitor #(
    .WINDOW(WINDOW)
  ) u_avg_mon (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .raw_rate   (raw_rate),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .avg_rate   (avg_rate),
    .window_fill(window_fill),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .bad_beats  (bad_beats),
    .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watchdog: a hung handshake shows up as a long run of cycles with no beat.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("gyro_rate_offset_moving_average_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver. Random back-pressure at out_idle_pct; once long_hold goes up it
  // holds off for HOLD_CYCLES so the result register and the input back up.
  initial begin
    bit hold_served;
    hold_served = 1'b0;
    out_ready   = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold && !hold_served) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served = 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  // Offers one beat and returns at the edge that takes it. Valid is only
  // dropped for an idle gap, so back-to-back beats keep it high.
  task automatic send_sample(input logic [RAW_W-1:0] s);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_rate <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender goes quiet until every owed average has come out. One edge first,
  // so the beat taken at the current edge is already counted.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Only called with the block idle (after wait_drained).
  task automatic load_settings(input logic [CFG_W-1:0] ofs, input logic [CFG_W-1:0] scale);
    cfg_we    <= 1'b1;
    cfg_index <= gyroma_pkg::REG_RATE_OFFSET;
    cfg_data  <= ofs;
    @(posedge clk);
    cfg_index <= gyroma_pkg::REG_RATE_SCALE;
    cfg_data  <= scale;  // bits above the scale width are dropped by the block
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly full-range noise, with weight on the rails (where saturation
  // lives at large scale/offset) and on small values around zero, where the
  // floor shift and the truncating divide disagree on sign.
  function automatic logic [RAW_W-1:0] pick_sample();
    int               r;
    logic [RAW_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 10) v = 16'h8000;
    else if (r < 20) v = 16'h7FFF;
    else if (r < 35) v = RAW_W'($urandom_range(0, 64) - 32);
    else v = RAW_W'($urandom);
    return v;
  endfunction

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    raw_rate     = '0;
    cfg_we       = 1'b0;
    cfg_index    = gyroma_pkg::REG_RATE_OFFSET;
    cfg_data     = '0;
    in_idle_pct  = 17;
    out_idle_pct = 53;
    long_hold    = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: window fills 1..10, then holds
    foreach (WARMUP[i]) send_sample(WARMUP[i]);

    // most negative offset with max scale: full negative raw clamps high
    wait_drained();
    load_settings(25'h1000000, 25'h003FFFF);
    send_sample(16'h8000);
    send_sample(16'h8000);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h0000);

    // most positive offset: full positive raw clamps low
    wait_drained();
    load_settings(25'h0FFFFFF, 25'h003FFFF);
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);

    // Random phases, each with its own register setting. Idling: sender light
    // and receiver heavy, then swapped, then none at all.
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      case (p)
        0:       load_settings('0, 25'h003FFFF);
        1:       load_settings(25'h1000000, 25'h003FFFF);
        2:       load_settings(25'h0FFFFFF, 25'h003FFFF);
        3:       load_settings(CFG_W'($urandom), '0);  // zero scale: output is -offset
        default: load_settings(CFG_W'($urandom), CFG_W'($urandom));
      endcase
      if (p == 4) begin
        in_idle_pct  <= 53;
        out_idle_pct <= 17;
      end else if (p == 7) begin
        in_idle_pct  <= 0;
        out_idle_pct <= 0;
      end
      if (p == 1) long_hold <= 1'b1;  // sender keeps offering through the hold
      repeat (PHASE_ITEMS) send_sample(pick_sample());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_beats == 0) begin
      $display("gyro_rate_offset_moving_average_tb passed");
    end else begin
      $display("gyro_rate_offset_moving_average_tb failed");
    end
    $finish;
  end

endmodule

[files.f]
src/gyroma_pkg.sv
src/gyroma_cell.sv
src/gyroma_div.sv
src/gyro_rate_offset_moving_average.sv
tb/sv/gyroma_avg_monitor.sv
tb/sv/gyro_rate_offset_moving_average_tb.sv
